[src/fpa_pkg.sv]
package fpa_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned AMT_W  = 32;
   localparam int unsigned SUM_W  = 64;
   localparam int unsigned PORT_W = 16;
   localparam int unsigned PATH_W = 32;
   localparam int unsigned CODE_W = 5;
   localparam int unsigned CSR_W  = 32;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_STOP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_LIMIT    = 2'd2;

   // outbound class weights
   localparam logic [CODE_W-1:0] OUT_NEVER  = 5'd12;
   localparam logic [CODE_W-1:0] OUT_NOTNOW = 5'd8;
   localparam logic [CODE_W-1:0] OUT_SPAN   = 5'd4;
   localparam logic [CODE_W-1:0] OUT_EVENT  = 5'd0;
   // inbound class weights
   localparam logic [CODE_W-1:0] IN_NEVER   = 5'd4;
   localparam logic [CODE_W-1:0] IN_NOTNOW  = 5'd3;
   localparam logic [CODE_W-1:0] IN_SPAN    = 5'd2;
   localparam logic [CODE_W-1:0] IN_EVENT   = 5'd1;

   localparam logic [CODE_W-1:0] CODE_MIN = 5'd1;
   localparam logic [CODE_W-1:0] CODE_MAX = 5'd16;

   // one direction's aggregate
   typedef struct packed {
      logic [TIME_W-1:0] first;
      logic [TIME_W-1:0] last;
      logic [SUM_W-1:0]  pkts;
      logic [SUM_W-1:0]  octets;
      logic [PATH_W-1:0] path;
   } dir_agg_type;

   // a record as seen by one direction (interface already chosen)
   typedef struct packed {
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] stop;
      logic [AMT_W-1:0]  pkts;
      logic [AMT_W-1:0]  octets;
      logic [PORT_W-1:0] router;
      logic [PORT_W-1:0] port;
   } dir_rec_type;

   typedef struct packed {
      logic [TIME_W-1:0] window_start;
      logic [TIME_W-1:0] window_stop;
      logic [TIME_W-1:0] age_limit;
   } csr_type;

   typedef struct packed {
      logic [CODE_W-1:0] window_code;
      logic              inactive;
   } status_type;

endpackage

[src/fpa_req_if.sv]
interface fpa_req_if;
   logic                           valid;
   logic                           ready;
   logic                           inbound;
   logic [fpa_pkg::TIME_W-1:0]     flow_start;
   logic [fpa_pkg::TIME_W-1:0]     flow_stop;
   logic [fpa_pkg::AMT_W-1:0]      flow_packets;
   logic [fpa_pkg::AMT_W-1:0]      flow_bytes;
   logic [fpa_pkg::PORT_W-1:0]     ingress_port;
   logic [fpa_pkg::PORT_W-1:0]     egress_port;
   logic [fpa_pkg::PORT_W-1:0]     router_id;

   modport source (
      output valid, inbound, flow_start, flow_stop, flow_packets, flow_bytes,
             ingress_port, egress_port, router_id,
      input  ready
   );
   modport sink (
      input  valid, inbound, flow_start, flow_stop, flow_packets, flow_bytes,
             ingress_port, egress_port, router_id,
      output ready
   );
endinterface

[src/fpa_rsp_if.sv]
interface fpa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fpa_pkg::CODE_W-1:0]     window_code;
   logic                           inactive;
   logic [fpa_pkg::TIME_W-1:0]     out_first;
   logic [fpa_pkg::TIME_W-1:0]     out_last;
   logic [fpa_pkg::SUM_W-1:0]      out_pkts;
   logic [fpa_pkg::SUM_W-1:0]      out_octets;
   logic [fpa_pkg::TIME_W-1:0]     in_first;
   logic [fpa_pkg::TIME_W-1:0]     in_last;
   logic [fpa_pkg::SUM_W-1:0]      in_pkts;
   logic [fpa_pkg::SUM_W-1:0]      in_octets;
   logic [fpa_pkg::PATH_W-1:0]     out_path;
   logic [fpa_pkg::PATH_W-1:0]     in_path;

   modport source (
      output valid, window_code, inactive, out_first, out_last, out_pkts,
             out_octets, in_first, in_last, in_pkts, in_octets, out_path, in_path,
      input  ready
   );
   modport sink (
      input  valid, window_code, inactive, out_first, out_last, out_pkts,
             out_octets, in_first, in_last, in_pkts, in_octets, out_path, in_path,
      output ready
   );
endinterface

[src/flow_pair_aggregator.sv]
// Path: an accepted req word passes the input register, then the result
//    register, to its rsp word; it is held there while rsp is stalled.
// Throughput: one word per cycle while rsp is not stalled; req stays ready
//    while the result register drains in the same cycle.
// Reset (synchronous, active high): clears both aggregates, the csr registers
//    and all valid flags; no clearing pass.
module flow_pair_aggregator (
   input  logic                          clock,
   input  logic                          reset,
   fpa_req_if.sink                       req_chan,
   fpa_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [fpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fpa_pkg::CSR_W-1:0]     csr_wdata
);

   // csr registers
   fpa_pkg::csr_type     csr_ff;

   // input register: one accepted word
   logic                 s1_valid_ff;
   logic                 s1_inbound_ff;
   fpa_pkg::dir_rec_type s1_rec_ff;

   // running aggregates per direction
   fpa_pkg::dir_agg_type out_agg_ff;
   fpa_pkg::dir_agg_type in_agg_ff;

   // result register
   logic                 rsp_valid_ff;
   fpa_pkg::dir_agg_type rsp_out_ff;
   fpa_pkg::dir_agg_type rsp_in_ff;
   fpa_pkg::status_type  rsp_status_ff;

   logic                 rsp_free;
   logic                 advance;
   logic                 req_take;
   fpa_pkg::dir_rec_type req_rec_in;
   fpa_pkg::dir_agg_type out_upd;
   fpa_pkg::dir_agg_type in_upd;
   fpa_pkg::dir_agg_type out_agg_in;
   fpa_pkg::dir_agg_type in_agg_in;
   fpa_pkg::status_type  status;

   // ---------------- handshake ----------------
   // Result register frees when empty or being taken; the input register moves
   // into it then, so a new req word can land in the same cycle.
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && rsp_free;
   assign req_chan.ready = !s1_valid_ff || rsp_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   // the interface number follows the direction of the record
   always_comb begin
      req_rec_in.start  = req_chan.flow_start;
      req_rec_in.stop   = req_chan.flow_stop;
      req_rec_in.pkts   = req_chan.flow_packets;
      req_rec_in.octets = req_chan.flow_bytes;
      req_rec_in.router = req_chan.router_id;
      req_rec_in.port   = req_chan.inbound ? req_chan.ingress_port : req_chan.egress_port;
   end

   // ---------------- csr writes ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fpa_pkg::CSR_WINDOW_START: csr_ff.window_start <= csr_wdata;
            fpa_pkg::CSR_WINDOW_STOP:  csr_ff.window_stop  <= csr_wdata;
            fpa_pkg::CSR_AGE_LIMIT:    csr_ff.age_limit    <= csr_wdata;
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // ---------------- input register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_inbound_ff <= req_chan.inbound;
         s1_rec_ff     <= req_rec_in;
      end
   end

   // ---------------- aggregate update ----------------
   fpa_dir_update u_out_update (
      .cur (out_agg_ff),
      .rec (s1_rec_ff),
      .nxt (out_upd)
   );

   fpa_dir_update u_in_update (
      .cur (in_agg_ff),
      .rec (s1_rec_ff),
      .nxt (in_upd)
   );

   // only the record's own direction moves
   assign out_agg_in = s1_inbound_ff ? out_agg_ff : out_upd;
   assign in_agg_in  = s1_inbound_ff ? in_upd : in_agg_ff;

   // classification sees the aggregates after this word's update
   fpa_classify u_classify (
      .out_agg (out_agg_in),
      .in_agg  (in_agg_in),
      .csr     (csr_ff),
      .status  (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_agg_ff <= '0;
         in_agg_ff  <= '0;
      end else if (advance) begin
         out_agg_ff <= out_agg_in;
         in_agg_ff  <= in_agg_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_out_ff    <= out_agg_in;
         rsp_in_ff     <= in_agg_in;
         rsp_status_ff <= status;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.window_code = rsp_status_ff.window_code;
   assign rsp_chan.inactive    = rsp_status_ff.inactive;
   assign rsp_chan.out_first   = rsp_out_ff.first;
   assign rsp_chan.out_last    = rsp_out_ff.last;
   assign rsp_chan.out_pkts    = rsp_out_ff.pkts;
   assign rsp_chan.out_octets  = rsp_out_ff.octets;
   assign rsp_chan.in_first    = rsp_in_ff.first;
   assign rsp_chan.in_last     = rsp_in_ff.last;
   assign rsp_chan.in_pkts     = rsp_in_ff.pkts;
   assign rsp_chan.in_octets   = rsp_in_ff.octets;
   assign rsp_chan.out_path    = rsp_out_ff.path;
   assign rsp_chan.in_path     = rsp_in_ff.path;

   // ---------------- assertions ----------------
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff.window_code >= fpa_pkg::CODE_MIN &&
                        rsp_status_ff.window_code <= fpa_pkg::CODE_MAX))
      else $error("window code out of range");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("word moved to result register but no rsp valid");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("req stalled with a free stage");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(out_agg_ff) && $stable(in_agg_ff)))
      else $error("aggregate changed without a word moving");

endmodule

[src/fpa_dir_update.sv]
module fpa_dir_update (
   input  fpa_pkg::dir_agg_type cur,
   input  fpa_pkg::dir_rec_type rec,
   output fpa_pkg::dir_agg_type nxt
);

   logic [fpa_pkg::SUM_W:0] pkt_sum;
   logic [fpa_pkg::SUM_W:0] oct_sum;

   assign pkt_sum = {1'b0, cur.pkts} + (fpa_pkg::SUM_W+1)'(rec.pkts);
   assign oct_sum = {1'b0, cur.octets} + (fpa_pkg::SUM_W+1)'(rec.octets);

   always_comb begin
      // zero start means unset, so any start replaces it (a zero start re-clears)
      nxt.first  = (cur.first == '0 || rec.start < cur.first) ? rec.start : cur.first;
      nxt.last   = (rec.stop > cur.last) ? rec.stop : cur.last;
      nxt.pkts   = pkt_sum[fpa_pkg::SUM_W] ? '1 : pkt_sum[fpa_pkg::SUM_W-1:0];
      nxt.octets = oct_sum[fpa_pkg::SUM_W] ? '1 : oct_sum[fpa_pkg::SUM_W-1:0];
      nxt.path   = {rec.router, rec.port};
   end

endmodule

[src/fpa_classify.sv]
module fpa_classify (
   input  fpa_pkg::dir_agg_type out_agg,
   input  fpa_pkg::dir_agg_type in_agg,
   input  fpa_pkg::csr_type     csr,
   output fpa_pkg::status_type  status
);

   logic [fpa_pkg::CODE_W-1:0] out_cls;
   logic [fpa_pkg::CODE_W-1:0] in_cls;

   always_comb begin
      if (out_agg.first == '0) begin
         out_cls = fpa_pkg::OUT_NEVER;
      end else if (out_agg.last < csr.window_start || out_agg.first > csr.window_stop) begin
         out_cls = fpa_pkg::OUT_NOTNOW;
      end else if (out_agg.first < csr.window_start && out_agg.last > csr.window_stop) begin
         out_cls = fpa_pkg::OUT_SPAN;
      end else begin
         out_cls = fpa_pkg::OUT_EVENT;
      end

      if (in_agg.first == '0) begin
         in_cls = fpa_pkg::IN_NEVER;
      end else if (in_agg.last < csr.window_start || in_agg.first > csr.window_stop) begin
         in_cls = fpa_pkg::IN_NOTNOW;
      end else if (in_agg.first < csr.window_start && in_agg.last > csr.window_stop) begin
         in_cls = fpa_pkg::IN_SPAN;
      end else begin
         in_cls = fpa_pkg::IN_EVENT;
      end

      status.window_code = out_cls + in_cls;
      status.inactive    = (out_agg.last < csr.age_limit) && (in_agg.last < csr.age_limit);
   end

endmodule
